FILE: sv/sxfd_pkg.sv
package sxfd_pkg;

    localparam int MOTOR_COUNT_CFG = 4;
    localparam int MOTOR_COUNT = (MOTOR_COUNT_CFG > 4) ? 4 :
                                 ((MOTOR_COUNT_CFG < 0) ? 0 : MOTOR_COUNT_CFG);

    localparam logic [7:0] SYNC_BYTE  = 8'hA5;
    localparam int         PACKET_LEN = 20;
    localparam int         POS_W      = 5;
    localparam logic [POS_W-1:0] POS_HUNT = POS_W'(0);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(PACKET_LEN - 1);

    localparam int DATA_BYTES = PACKET_LEN - 2;
    localparam int FRAME_W    = 16 + 4 * 32;

    localparam logic [FRAME_W-1:0] SPEED_UNUSED_MASK = {FRAME_W{1'b1}} << (16 + 32 * MOTOR_COUNT);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        CMD_DATA   = 1'b0,
        CMD_COMMIT = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
    } t_cmd;

endpackage

FILE: sv/sxfd_front.sv
module sxfd_front
    import sxfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_room,
    output logic       o_ready,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [7:0]       r_csum;
    logic [7:0]       n_csum;
    logic             w_take;
    logic             w_hunt;

    assign o_ready = i_room;
    assign w_take  = i_valid && i_room;
    assign w_hunt  = (r_pos == POS_HUNT) || (r_pos > POS_LAST);

    always_comb begin
        n_pos      = r_pos;
        n_csum     = r_csum;
        o_push     = 1'b0;
        o_cmd.kind = CMD_DATA;
        o_cmd.data = i_byte;
        if (w_take) begin
            priority if (w_hunt) begin
                if (i_byte == SYNC_BYTE) begin
                    n_pos  = POS_W'(1);
                    n_csum = i_byte;
                end else begin
                    n_pos = POS_HUNT;
                end
            end else if (r_pos == POS_LAST) begin
                n_pos      = POS_HUNT;
                n_csum     = 8'h00;
                o_push     = (r_csum == i_byte);
                o_cmd.kind = CMD_COMMIT;
            end else begin
                n_pos  = r_pos + POS_W'(1);
                n_csum = r_csum ^ i_byte;
                o_push = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_HUNT;
            r_csum <= 8'h00;
        end else begin
            r_pos  <= n_pos;
            r_csum <= n_csum;
        end
    end

endmodule

FILE: sv/sxfd_queue.sv
module sxfd_queue
    import sxfd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_room,
    output logic o_avail,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_pop;

    assign o_room  = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_avail = (r_cnt != QCNT_W'(0));
    assign o_cmd   = r_mem[r_rptr];
    assign w_pop   = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(w_pop);
        end
    end

endmodule

FILE: sv/sxfd_back.sv
module sxfd_back
    import sxfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_avail,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [FRAME_W-1:0] o_data
);

    logic [7:0]         r_pkt [DATA_BYTES];
    logic [FRAME_W-1:0] r_frame;
    logic [FRAME_W-1:0] w_frame;
    logic               r_valid;
    logic               w_free;
    logic               w_load;

    assign w_free  = !r_valid || i_ready;
    assign o_pop   = i_avail && ((i_cmd.kind == CMD_DATA) || w_free);
    assign w_load  = o_pop && (i_cmd.kind == CMD_COMMIT);
    assign o_valid = r_valid;
    assign o_data  = r_frame;

    always_comb begin
        w_frame        = '0;
        w_frame[15:0]  = {r_pkt[1], r_pkt[0]};
        for (int m = 0; m < MOTOR_COUNT; m++) begin
            w_frame[16 + 32*m +: 32] = {r_pkt[2 + 4*m + 3], r_pkt[2 + 4*m + 2],
                                        r_pkt[2 + 4*m + 1], r_pkt[2 + 4*m]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_cmd.kind == CMD_DATA)) begin
            for (int i = 0; i < DATA_BYTES - 1; i++) begin
                r_pkt[i] <= r_pkt[i + 1];
            end
            r_pkt[DATA_BYTES - 1] <= i_cmd.data;
        end
        if (w_load) begin
            r_frame <= w_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

FILE: sv/sync_xor_frame_deframer.sv
// Takes one received byte per transfer and drops bytes until the sync byte 0xA5, then
// collects a 20-byte packet whose last byte must equal the XOR of the 19 bytes before it
// (sync included); a sync byte inside a packet is plain data. A good packet yields one
// frame transfer; a bad one is dropped and hunting restarts with the next byte. One byte
// is taken every cycle: the front tracks position and checksum as bytes are taken, and a
// four-entry queue feeds the back end, which assembles the frame into an output register,
// so the input stalls only when that queue fills behind a held frame. The last byte of a
// good packet queues a commit entry, and the frame is loaded into the output register once
// that entry reaches the head of the queue and the register is free.
module sync_xor_frame_deframer
    import sxfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [7:0]         i_s_axis_tdata,  // [7:0] rx_byte
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [FRAME_W-1:0] o_m_axis_tdata   // [15:0] frame_duration, [47:16] speed_motor0,
                                                // [79:48] speed_motor1, [111:80] speed_motor2,
                                                // [143:112] speed_motor3
);

    logic w_room;
    logic w_push;
    t_cmd w_push_cmd;
    logic w_avail;
    t_cmd w_head_cmd;
    logic w_pop;

    sxfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_byte  (i_s_axis_tdata),
        .i_room  (w_room),
        .o_ready (o_s_axis_tready),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    sxfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_room  (w_room),
        .o_avail (w_avail),
        .o_cmd   (w_head_cmd),
        .i_pop   (w_pop)
    );

    sxfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (w_avail),
        .i_cmd   (w_head_cmd),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule

FILE: sv/sxfd_checker.sv
module sxfd_checker
    import sxfd_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_s_axis_tvalid,
    input logic               o_s_axis_tready,
    input logic [7:0]         i_s_axis_tdata,
    input logic               o_m_axis_tvalid,
    input logic               i_m_axis_tready,
    input logic [FRAME_W-1:0] o_m_axis_tdata
);

    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> (o_s_axis_tready && !o_m_axis_tvalid))
        else $error("outputs not cleared after reset");

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled frame changed");

    a_unused_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tdata & SPEED_UNUSED_MASK) == '0))
        else $error("speed of absent motor not zero");

    a_in_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && !o_s_axis_tready) |=>
        (i_s_axis_tvalid && $stable(i_s_axis_tdata)))
        else $error("stalled input byte changed");

    a_ready_when_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with no frame held");

endmodule

bind sync_xor_frame_deframer sxfd_checker u_sxfd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

FILE: tb/sync_xor_frame_deframer_tb.sv
module sync_xor_frame_deframer_tb;
    import sxfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    class frame_tracker;
        logic [POS_W-1:0]   pos;
        logic [7:0]         csum;
        logic [7:0]         pkt [PACKET_LEN];
        logic [FRAME_W-1:0] pending_frames [$];
        int                 errors;

        function new();
            pos        = POS_HUNT;
            csum       = 8'h00;
            errors     = 0;
        endfunction

        task report(input string what, input logic [31:0] got, input logic [31:0] want);
            $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        // advance the deframer state by one accepted byte
        function void take_byte(input logic [7:0] b);
            logic [FRAME_W-1:0] f;
            if (pos == POS_HUNT || pos > POS_LAST) begin
                if (b == SYNC_BYTE) begin
                    pkt[0] = b;
                    csum   = b;
                    pos    = POS_W'(1);
                end else begin
                    pos = POS_HUNT;
                end
            end else begin
                pkt[pos] = b;
                if (pos != POS_LAST) begin
                    csum = csum ^ b;
                    pos  = pos + POS_W'(1);
                end else begin
                    pos = POS_HUNT;
                    if (csum == b) begin
                        f        = '0;
                        f[15:0]  = {pkt[2], pkt[1]};
                        for (int m = 0; m < 4; m++) begin
                            if (m < MOTOR_COUNT)
                                f[16 + 32*m +: 32] = {pkt[6 + 4*m], pkt[5 + 4*m],
                                                      pkt[4 + 4*m], pkt[3 + 4*m]};
                        end
                        pending_frames.push_back(f);
                    end
                    csum = 8'h00;
                end
            end
        endfunction

        task check_frame(input logic [FRAME_W-1:0] got);
            logic [FRAME_W-1:0] want;
            if (pending_frames.size() == 0) begin
                report("unexpected frame, duration", 32'(got[15:0]), 32'h0);
            end else begin
                want = pending_frames.pop_front();
                if (got[15:0] !== want[15:0])
                    report("frame_duration", 32'(got[15:0]), 32'(want[15:0]));
                for (int m = 0; m < 4; m++) begin
                    if (got[16 + 32*m +: 32] !== want[16 + 32*m +: 32])
                        report($sformatf("speed_motor%0d", m),
                               got[16 + 32*m +: 32], want[16 + 32*m +: 32]);
                end
            end
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_valid = 1'b0;
    logic [7:0]         s_data = 8'h00;
    logic               m_ready = 1'b0;
    logic               o_s_axis_tready;
    logic               o_m_axis_tvalid;
    logic [FRAME_W-1:0] o_m_axis_tdata;

    frame_tracker tracker = new();
    int           src_idle_pct = 0;
    int           sink_stall_pct = 0;
    int           bytes_sent = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    sync_xor_frame_deframer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),          // [7:0] rx_byte
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)   // [15:0] duration, then speed_motor0..3, 32 each
    );

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && m_ready)
                tracker.check_frame(o_m_axis_tdata);
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        tracker.take_byte(b);
        bytes_sent++;
    endtask

    task automatic send_packet(input logic [7:0] body [DATA_BYTES], input bit corrupt);
        logic [7:0] sum;
        sum = SYNC_BYTE;
        send_byte(SYNC_BYTE);
        foreach (body[i]) begin
            sum = sum ^ body[i];
            send_byte(body[i]);
        end
        if (corrupt)
            sum = sum ^ 8'($urandom_range(255, 1));
        send_byte(sum);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return SYNC_BYTE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic pick_idling();
        case ((bytes_sent / 100) % 5)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 86; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 86; end
            3: begin src_idle_pct = 34; sink_stall_pct = 34; end
            default: begin src_idle_pct = 0; sink_stall_pct = 0; end
        endcase
    endtask

    initial begin
        logic [7:0] body [DATA_BYTES];
        int         kind;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // noise while hunting, then one packet with extreme and sync-valued data
        send_byte(8'h00);
        send_byte(8'hFF);
        foreach (body[i]) begin
            case (i / 4)
                0:       body[i] = 8'hFF;
                1:       body[i] = 8'h00;
                2:       body[i] = SYNC_BYTE;
                default: body[i] = 8'(8'h5A ^ i);
            endcase
        end
        send_packet(body, 1'b0);

        while (bytes_sent < 1200) begin
            pick_idling();
            kind = $urandom_range(99);
            if (kind < 13) begin
                repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
            end else begin
                foreach (body[i]) body[i] = pick_byte();
                send_packet(body, kind < 25);
            end
        end
        s_valid <= 1'b0;

        while (tracker.pending_frames.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

FILE: sync_xor_frame_deframer.f
sv/sxfd_pkg.sv
sv/sxfd_front.sv
sv/sxfd_queue.sv
sv/sxfd_back.sv
sv/sync_xor_frame_deframer.sv
sv/sxfd_checker.sv
tb/sync_xor_frame_deframer_tb.sv
